[sv/nfsa_pkg.sv]
// ---------------------------------------------------------------------------
// nfsa_pkg: shared types for the next-fit segment allocator
// Payload structs, chain carry record, commit broadcast, command codes.
// ---------------------------------------------------------------------------
package nfsa_pkg;

  localparam int NSEG   = 16;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 5;
  localparam int ADDR_W = 32;
  localparam int SIZE_W = 31;
  localparam int TOT_W  = 32;

  localparam logic [CNT_W-1:0] SEG_USE_RESET = CNT_W'(NSEG);

  // command codes
  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_ALLOC   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NORM,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  seg_index;
    logic [ADDR_W-1:0] seg_address;
    logic [SIZE_W-1:0] req_size;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] result_address;
    logic [IDX_W-1:0]  result_index;
    logic [TOT_W-1:0]  alloc_total;
    logic [TOT_W-1:0]  release_total;
    logic [CNT_W-1:0]  free_segments;
  } out_item_t;

  // request seen by every cell while an item is in flight
  typedef struct packed {
    logic [1:0]        cmd;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    logic [CNT_W-1:0]  n;
    logic [IDX_W-1:0]  start;
  } req_t;

  // record handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              hi_found;
    logic [IDX_W-1:0]  hi_idx;
    logic [ADDR_W-1:0] hi_addr;
    logic              lo_found;
    logic [IDX_W-1:0]  lo_idx;
    logic [ADDR_W-1:0] lo_addr;
    logic              rel_found;
    logic [IDX_W-1:0]  rel_idx;
    logic [CNT_W-1:0]  free_cnt;
  } carry_t;

  // state update broadcast to all cells
  typedef struct packed {
    logic             load;
    logic             take;
    logic             clear;
    logic [IDX_W-1:0] index;
  } commit_t;

endpackage

[sv/nfsa_cell.sv]
// ---------------------------------------------------------------------------
// nfsa_cell: one segment slot of the allocator chain
// Holds base, size and taken mark; folds its own status into the record
// passed on to the next cell each cycle.
// ---------------------------------------------------------------------------
module nfsa_cell
  import nfsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] position,
  input  req_t             req,
  input  commit_t          commit,
  input  carry_t           carry_in,
  output carry_t           carry_out
);

  logic [ADDR_W-1:0] base;
  logic [SIZE_W-1:0] len;
  logic              taken;

  logic   active;
  logic   fit;
  logic   hit_me;
  carry_t carry_next;

  assign active = {1'b0, position} < req.n;
  assign fit    = active && !taken && (len >= req.size);
  assign hit_me = commit.index == position;

  // segment state
  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      len   <= '0;
      taken <= 1'b0;
    end else if (hit_me) begin
      if (commit.load) begin
        base  <= req.addr;
        len   <= req.size;
        taken <= 1'b0;
      end else if (commit.take) begin
        taken <= 1'b1;
      end else if (commit.clear) begin
        taken <= 1'b0;
      end
    end
  end

  // fold this slot into the record
  always_comb begin
    carry_next = carry_in;
    if (!carry_in.hi_found && fit && (position >= req.start)) begin
      carry_next.hi_found = 1'b1;
      carry_next.hi_idx   = position;
      carry_next.hi_addr  = base;
    end
    if (!carry_in.lo_found && fit) begin
      carry_next.lo_found = 1'b1;
      carry_next.lo_idx   = position;
      carry_next.lo_addr  = base;
    end
    if (!carry_in.rel_found && active && taken && (base == req.addr)) begin
      carry_next.rel_found = 1'b1;
      carry_next.rel_idx   = position;
    end
    // a slot about to be loaded counts as free
    if (active && (!taken || ((req.cmd == CMD_LOAD) && (req.idx == position)))) begin
      carry_next.free_cnt = carry_in.free_cnt + CNT_W'(1);
    end
  end

  // hand the record to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      carry_out <= '0;
    end else begin
      carry_out <= carry_next;
    end
  end

endmodule

[sv/next_fit_segment_allocator.sv]
// ---------------------------------------------------------------------------
// next_fit_segment_allocator: segment table with next-fit allocation
// Sequencer, totals and result register around a chain of segment cells.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer (load, allocate, free by address).
//   out_* : one result per command, in order, with both totals and the
//           number of free segments after the command.
//   cfg_* : segments_in_use; the user writes it only while the block is idle,
//           which the block itself does not enforce.
// Flow: a command walks the cell chain one cell per cycle. The input
//   transfer is taken in idle, then the normalize check injects the record
//   into the chain, the record passes all 16 cells, the last record is
//   captured, and commit writes the result and raises out_valid. After the
//   segment count is lowered the next-fit pointer is first reduced by one
//   subtraction per extra normalize cycle. One command is in flight at a
//   time; the next transfer is taken only back in idle after the commit.
// A finished result sits in the output register; the next command is taken
//   while it waits, and only the commit of that next command stalls behind
//   a receiver that holds out_ready low.
// Reset clears the whole table, the pointer and the totals, and sets
//   segments_in_use to 16.
// ---------------------------------------------------------------------------
module next_fit_segment_allocator
  import nfsa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  state_t state, state_next;

  logic [CNT_W-1:0] segments_in_use;
  logic [IDX_W-1:0] search_start, search_start_next;
  logic [TOT_W-1:0] grant_count, grant_count_next;
  logic [TOT_W-1:0] release_count, release_count_next;
  req_t             req;
  carry_t           tail;

  logic [CNT_W-1:0] n_eff;
  logic             inject;
  logic             commit_go;
  logic             alloc_found;
  logic [IDX_W-1:0] alloc_idx;
  logic [ADDR_W-1:0] alloc_addr;
  commit_t          commit;
  out_item_t        result;
  carry_t           chain [NSEG+1];

  // effective segment count
  always_comb begin
    priority if (segments_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if (segments_in_use > CNT_W'(NSEG)) begin
      n_eff = CNT_W'(NSEG);
    end else begin
      n_eff = segments_in_use;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      segments_in_use <= SEG_USE_RESET;
    end else if (cfg_we) begin
      segments_in_use <= cfg_wdata;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    inject     = 1'b0;
    commit_go  = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        if ({1'b0, req.start} < req.n) begin
          inject     = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[NSEG].valid) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!out_valid || out_ready) begin
          commit_go  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // request register, pointer reduced modulo the count in the normalize step
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      req.cmd   <= in_data.cmd;
      req.idx   <= in_data.seg_index;
      req.addr  <= in_data.seg_address;
      req.size  <= in_data.req_size;
      req.n     <= n_eff;
      req.start <= search_start;
    end else if (state == ST_NORM && !inject) begin
      req.start <= req.start - req.n[IDX_W-1:0];
    end
  end

  // cell chain
  assign chain[0] = '{valid: inject, default: '0};

  for (genvar g = 0; g < NSEG; g++) begin : g_cell
    nfsa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .position  (IDX_W'(g)),
      .req       (req),
      .commit    (commit),
      .carry_in  (chain[g]),
      .carry_out (chain[g+1])
    );
  end

  // capture the record leaving the last cell
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && chain[NSEG].valid) begin
      tail <= chain[NSEG];
    end
  end

  // decide the command outcome
  assign alloc_found = tail.hi_found || tail.lo_found;
  assign alloc_idx   = tail.hi_found ? tail.hi_idx  : tail.lo_idx;
  assign alloc_addr  = tail.hi_found ? tail.hi_addr : tail.lo_addr;

  always_comb begin
    commit             = '0;
    search_start_next  = search_start;
    grant_count_next   = grant_count;
    release_count_next = release_count;
    result             = '0;
    result.free_segments = tail.free_cnt;
    unique case (req.cmd)
      CMD_LOAD: begin
        commit.load         = commit_go;
        commit.index        = req.idx;
        result.ok           = 1'b1;
        result.result_index = req.idx;
      end
      CMD_ALLOC: begin
        if (alloc_found) begin
          commit.take           = commit_go;
          commit.index          = alloc_idx;
          grant_count_next      = grant_count + TOT_W'(1);
          search_start_next     = (({1'b0, alloc_idx} + CNT_W'(1)) == req.n) ?
                                  '0 : alloc_idx + IDX_W'(1);
          result.ok             = 1'b1;
          result.result_address = alloc_addr;
          result.result_index   = alloc_idx;
          result.free_segments  = tail.free_cnt - CNT_W'(1);
        end
      end
      CMD_RELEASE: begin
        if (tail.rel_found) begin
          commit.clear         = commit_go;
          commit.index         = tail.rel_idx;
          release_count_next   = release_count + TOT_W'(1);
          result.ok            = 1'b1;
          result.result_index  = tail.rel_idx;
          result.free_segments = tail.free_cnt + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    result.alloc_total   = grant_count_next;
    result.release_total = release_count_next;
  end

  // pointer and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      search_start  <= '0;
      grant_count   <= '0;
      release_count <= '0;
    end else if (commit_go) begin
      search_start  <= search_start_next;
      grant_count   <= grant_count_next;
      release_count <= release_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_data <= result;
    end
  end

  // only one record travels the chain at a time, checked at the first, middle and last cell outputs
  a_single_wave: assert property (@(posedge clk) disable iff (rst)
    $onehot0({chain[NSEG].valid, chain[NSEG/2].valid, chain[1].valid}))
    else $error("more than one record in the cell chain");

  // a record leaves the chain only during the scan
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[NSEG].valid |-> state == ST_SCAN)
    else $error("chain record outside scan");

  // commit never overwrites a result that was not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    commit_go |-> (!out_valid || out_ready))
    else $error("result overwritten");

  // pointer inside the granting command's count after every grant
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    (commit_go && commit.take) |=> ({1'b0, search_start} < req.n))
    else $error("next-fit pointer out of range");

endmodule

[test/next_fit_segment_allocator_tb.sv]
// ---------------------------------------------------------------------------
// next_fit_segment_allocator_tb: self-checking bench for the segment allocator
// Drives load, allocate and free commands with bursty valid and a stalling
// receiver, predicts every result from a local copy of the segment table and
// compares each output transfer field by field, in order.
// ---------------------------------------------------------------------------
module next_fit_segment_allocator_tb;
  import nfsa_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_ITEMS  = 1450;

  logic             clk;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  // local copy of the allocator state
  logic [ADDR_W-1:0] mdl_base [NSEG];
  logic [SIZE_W-1:0] mdl_len [NSEG];
  bit                mdl_taken [NSEG];
  int unsigned       mdl_ptr;
  logic [TOT_W-1:0]  mdl_grants;
  logic [TOT_W-1:0]  mdl_releases;
  logic [CNT_W-1:0]  mdl_seg_use;

  // segments as loaded by the stimulus, used to aim allocs and frees
  logic [ADDR_W-1:0] pool_base [NSEG];
  logic [SIZE_W-1:0] pool_len [NSEG];

  out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        items_sent     = 0;
  int        burst_left     = 0;
  bit        hold_req       = 1'b0;
  int        hold_count     = 0;
  int        stall_phase    = 0;
  logic [15:0] stall_pattern;

  next_fit_segment_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #6_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // load, next-fit search, release by address and totals for one command
  function automatic out_item_t predict_segment_result(input in_item_t item);
    out_item_t   res;
    int unsigned span;
    int unsigned first;
    int unsigned slot;
    int unsigned i;
    int unsigned free_cnt;
    res = '0;
    span = (mdl_seg_use == 0) ? 1 : ((mdl_seg_use > NSEG) ? NSEG : mdl_seg_use);
    case (item.cmd)
      CMD_LOAD: begin
        mdl_base[item.seg_index]  = item.seg_address;
        mdl_len[item.seg_index]   = item.req_size;
        mdl_taken[item.seg_index] = 1'b0;
        res.ok = 1'b1;
        res.result_index = item.seg_index;
      end
      CMD_ALLOC: begin
        first = mdl_ptr % span;
        for (i = 0; i < span; i++) begin
          slot = (first + i) % span;
          if (!mdl_taken[slot] && mdl_len[slot] >= item.req_size) begin
            mdl_taken[slot] = 1'b1;
            mdl_grants = mdl_grants + TOT_W'(1);
            mdl_ptr = (slot + 1) % span;
            res.ok = 1'b1;
            res.result_address = mdl_base[slot];
            res.result_index = IDX_W'(slot);
            break;
          end
        end
      end
      CMD_RELEASE: begin
        for (i = 0; i < span; i++) begin
          if (mdl_taken[i] && mdl_base[i] == item.seg_address) begin
            mdl_taken[i] = 1'b0;
            mdl_releases = mdl_releases + TOT_W'(1);
            res.ok = 1'b1;
            res.result_index = IDX_W'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    free_cnt = 0;
    for (i = 0; i < span; i++)
      if (!mdl_taken[i]) free_cnt++;
    res.alloc_total   = mdl_grants;
    res.release_total = mdl_releases;
    res.free_segments = CNT_W'(free_cnt);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic compare_result(input out_item_t got, input out_item_t want);
    if (got.ok !== want.ok) report_mismatch("ok", 64'(got.ok), 64'(want.ok));
    if (got.result_address !== want.result_address)
      report_mismatch("result_address", 64'(got.result_address),
                      64'(want.result_address));
    if (got.result_index !== want.result_index)
      report_mismatch("result_index", 64'(got.result_index), 64'(want.result_index));
    if (got.alloc_total !== want.alloc_total)
      report_mismatch("alloc_total", 64'(got.alloc_total), 64'(want.alloc_total));
    if (got.release_total !== want.release_total)
      report_mismatch("release_total", 64'(got.release_total),
                      64'(want.release_total));
    if (got.free_segments !== want.free_segments)
      report_mismatch("free_segments", 64'(got.free_segments),
                      64'(want.free_segments));
  endtask

  // check result transfers first, then predict for the input transfer
  always @(posedge clk) begin : result_check
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0)
          report_mismatch("result with nothing pending", 64'(out_data.result_index),
                          64'(0));
        else
          compare_result(out_data, pending_results.pop_front());
      end
      if (in_valid && in_ready)
        pending_results.push_back(predict_segment_result(in_data));
    end
  end

  // receiver: random stall patterns, or a long hold-off on request
  always @(posedge clk) begin : result_drain
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        hold_count = 0;
        hold_req = 1'b0;
      end
    end else begin
      if (stall_phase == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'hFFFF;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom | $urandom);
          default: stall_pattern = 16'($urandom & $urandom);
        endcase
        stall_phase = 16;
      end
      stall_phase--;
      out_ready <= stall_pattern[stall_phase];
    end
  end

  function automatic in_item_t make_item(input logic [1:0] cmd,
                                         input logic [IDX_W-1:0] idx,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [SIZE_W-1:0] size);
    in_item_t item;
    item.cmd         = cmd;
    item.seg_index   = idx;
    item.seg_address = addr;
    item.req_size    = size;
    return item;
  endfunction

  // one input transfer, with bursts and random gaps in between
  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // drop valid and wait until every pending result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seg_use(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_we      <= 1'b1;
    cfg_wdata   <= value;
    mdl_seg_use = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // cleared table: zero-size alloc takes a never loaded segment
  task automatic test_after_reset();
    send_item(make_item(CMD_ALLOC, '0, '0, '0));
    send_item(make_item(CMD_RELEASE, '0, 32'h0000_1234, '0));
    send_item(make_item(CMD_RELEASE, '0, '0, '0));
    send_item(make_item(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
  endtask

  // field extremes, no fit, no match, load over a taken segment
  task automatic test_table_extremes();
    send_item(make_item(CMD_LOAD, 4'd0, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    send_item(make_item(CMD_LOAD, 4'd15, 32'h0000_0000, 31'h0000_0000));
    send_item(make_item(CMD_LOAD, 4'd7, 32'hA5A5_A5A5, 31'h5A5A_5A5A));
    send_item(make_item(CMD_ALLOC, '0, '0, 31'h7FFF_FFFF));
    send_item(make_item(CMD_ALLOC, '0, '0, 31'h7FFF_FFFF));
    send_item(make_item(CMD_ALLOC, '0, '0, '0));
    send_item(make_item(CMD_LOAD, 4'd1, 32'h5A5A_5A5A, 31'h25A5_A5A5));
    send_item(make_item(CMD_RELEASE, '0, 32'hFFFF_FFFF, '0));
    send_item(make_item(CMD_RELEASE, '0, 32'hA5A5_A5A5, '0));
  endtask

  // count of zero, above the table, load outside, pointer beyond count
  task automatic test_segment_count();
    write_seg_use(5'd0);
    send_item(make_item(CMD_ALLOC, '0, '0, '0));
    send_item(make_item(CMD_ALLOC, '0, '0, '0));
    send_item(make_item(CMD_LOAD, 4'd9, 32'h0F0F_0F0F, 31'd100));
    send_item(make_item(CMD_RELEASE, '0, 32'hFFFF_FFFF, '0));
    write_seg_use(5'd31);
    repeat (3) send_item(make_item(CMD_ALLOC, '0, '0, '0));
    write_seg_use(5'd2);
    send_item(make_item(CMD_ALLOC, '0, '0, '0));
    write_seg_use(SEG_USE_RESET);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    wait_idle();
    @(negedge clk);
    hold_req = 1'b1;
    @(posedge clk);
    burst_left = 20;
    repeat (8) send_item(make_item(CMD_ALLOC, '0, '0, SIZE_W'($urandom_range(0, 64))));
    wait (!hold_req);
    wait_idle();
  endtask

  function automatic logic [ADDR_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return pool_base[$urandom_range(0, NSEG - 1)];
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_request();
    logic [SIZE_W-1:0] len;
    len = pool_len[$urandom_range(0, NSEG - 1)];
    case ($urandom_range(0, 5))
      0: return len;
      1: return len + SIZE_W'(1);
      2: return '0;
      3: return SIZE_W'($urandom);
      default: return SIZE_W'($urandom_range(0, len));
    endcase
  endfunction

  task automatic send_load(input logic [IDX_W-1:0] idx);
    pool_base[idx] = pick_base();
    pool_len[idx]  = pick_length();
    send_item(make_item(CMD_LOAD, idx, pool_base[idx], pool_len[idx]));
  endtask

  // rounds of: new count, fill or four loads, mixed allocs, frees, loads, noise
  task automatic test_random_traffic();
    int          target;
    int          round;
    int          ops;
    int          roll;
    in_item_t    item;
    target = items_sent + RANDOM_ITEMS;
    round  = 0;
    while (items_sent < target) begin
      case ($urandom_range(0, 7))
        0: write_seg_use(5'd0);
        1: write_seg_use(5'd1);
        2: write_seg_use(5'd16);
        3: write_seg_use(5'd31);
        default: write_seg_use(CNT_W'($urandom_range(0, 31)));
      endcase
      if (round % 2 == 0) begin
        for (int k = 0; k < NSEG; k++) send_load(IDX_W'(k));
      end else begin
        repeat (4) send_load(IDX_W'($urandom_range(0, NSEG - 1)));
      end
      ops = $urandom_range(20, 60);
      repeat (ops) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          send_item(make_item(CMD_ALLOC, IDX_W'($urandom), ADDR_W'($urandom),
                              pick_request()));
        end else if (roll < 85) begin
          send_item(make_item(CMD_RELEASE, IDX_W'($urandom),
                              pool_base[$urandom_range(0, NSEG - 1)], SIZE_W'($urandom)));
        end else if (roll < 93) begin
          send_load(IDX_W'($urandom_range(0, NSEG - 1)));
        end else begin
          // noise: any command, any field values
          item = make_item(2'($urandom), IDX_W'($urandom), ADDR_W'($urandom),
                           SIZE_W'($urandom));
          if (item.cmd == CMD_LOAD) begin
            pool_base[item.seg_index] = item.seg_address;
            pool_len[item.seg_index]  = item.req_size;
          end
          send_item(item);
        end
      end
      round++;
    end
  endtask

  initial begin
    for (int k = 0; k < NSEG; k++) begin
      mdl_base[k]  = '0;
      mdl_len[k]   = '0;
      mdl_taken[k] = 1'b0;
      pool_base[k] = '0;
      pool_len[k]  = '0;
    end
    mdl_ptr      = 0;
    mdl_grants   = '0;
    mdl_releases = '0;
    mdl_seg_use  = SEG_USE_RESET;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_after_reset();
    test_table_extremes();
    test_segment_count();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/nfsa_pkg.sv
sv/nfsa_cell.sv
sv/next_fit_segment_allocator.sv
test/next_fit_segment_allocator_tb.sv
